// ----- rtl/gsm_pkg.sv -----
// Shared types and constants of the grid module sample point mapper.
`default_nettype none
package gsm_pkg;

  localparam int COORD_W     = 16;  // unsigned Q12.4 coordinate
  localparam int IDX_W       = 8;   // module index
  localparam int DIST_W      = 8;   // modules between finder centers
  localparam int DEN_W       = 16;  // D*(D-3)
  localparam int PROD_W      = 24;  // coordinate times distance
  localparam int STEP_W      = 26;  // signed axis step, D times a span
  localparam int OFS_W       = 10;  // signed index offset
  localparam int NUM_W       = 36;  // signed numerator
  localparam int RN_W        = 37;  // 2*|num| + den
  localparam int D2_W        = 17;  // 2*den
  localparam int OUT_W       = 18;  // signed Q13.4 result
  localparam int Q_W         = 18;  // quotient bits
  localparam int AXES        = 2;   // x is axis 0, y is axis 1

  localparam int FRONT_STAGES = 6;
  localparam int DIV_STAGES   = Q_W;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + 1;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes, byte address bits 4..2
  localparam logic [2:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [2:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [2:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [2:0] REG_ALIGNMENT    = 3'd3;
  localparam logic [2:0] REG_MODULES      = 3'd4;

  localparam logic [DIST_W-1:0] DIST_RESET = 8'd14;
  localparam logic [DIST_W-1:0] DIST_MIN   = 8'd4;
  localparam logic [DIST_W-1:0] FINDER_OFS = 8'd3;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;
  localparam logic [Q_W-1:0]          NEG_LIMIT = 18'd131072;

  // per-axis values derived from the configuration
  typedef struct packed {
    logic [PROD_W-1:0]        tl_d;    // TL*D
    logic [DEN_W+COORD_W-1:0] al_den;  // A*D*(D-3)
    logic signed [STEP_W-1:0] xs;      // D*(A-BLn)
    logic signed [STEP_W-1:0] ys;      // D*(A-TRn)
    logic signed [STEP_W-1:0] dtr;     // TR-TL
    logic signed [STEP_W-1:0] dbl;     // BL-TL
  } axis_cfg_t;

  typedef struct packed {
    axis_cfg_t [AXES-1:0] ax;
    logic [DIST_W-1:0]    dist_now;   // clamped D, straight from the register
    logic [DIST_W-1:0]    dist_clamp; // clamped D, registered
    logic [DEN_W-1:0]     den;        // D*(D-3), registered
  } cfg_t;

  // one axis entering the divider
  typedef struct packed {
    logic [RN_W-1:0] rn;
    logic [D2_W-1:0] d2;
    logic            neg;
    logic            ovf;
  } div_in_t;

endpackage
`default_nettype wire

// ----- rtl/gsm_cfg.sv -----
// Register file and derived frame constants of the sample point mapper.
`default_nettype none
module gsm_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gsm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [gsm_pkg::DATA_W-1:0] pwdata,
  output logic      [gsm_pkg::DATA_W-1:0] prdata,
  output gsm_pkg::cfg_t                   cfg
);

  logic [31:0] top_left;
  logic [31:0] top_right;
  logic [31:0] bottom_left;
  logic [31:0] alignment;
  logic [gsm_pkg::DIST_W-1:0] modules;

  logic wr;
  logic [gsm_pkg::DIST_W-1:0] dq;

  // first level of derived values
  logic [gsm_pkg::DIST_W-1:0] dist_clamp;
  logic [gsm_pkg::DEN_W-1:0]  den;
  logic [gsm_pkg::PROD_W-1:0] al_d  [gsm_pkg::AXES];
  logic [gsm_pkg::PROD_W-1:0] bl_m  [gsm_pkg::AXES];
  logic [gsm_pkg::PROD_W-1:0] tr_m  [gsm_pkg::AXES];
  logic [gsm_pkg::PROD_W-1:0] tl_d  [gsm_pkg::AXES];
  logic [gsm_pkg::COORD_W+1:0] tl_3 [gsm_pkg::AXES];

  // second level
  logic signed [gsm_pkg::STEP_W-1:0] xs  [gsm_pkg::AXES];
  logic signed [gsm_pkg::STEP_W-1:0] ys  [gsm_pkg::AXES];
  logic signed [gsm_pkg::STEP_W-1:0] dtr [gsm_pkg::AXES];
  logic signed [gsm_pkg::STEP_W-1:0] dbl [gsm_pkg::AXES];
  logic [gsm_pkg::DEN_W+gsm_pkg::COORD_W-1:0] al_den [gsm_pkg::AXES];

  assign wr = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      top_left    <= '0;
      top_right   <= '0;
      bottom_left <= '0;
      alignment   <= '0;
      modules     <= gsm_pkg::DIST_RESET;
    end else if (wr) begin
      unique case (paddr[4:2])
        gsm_pkg::REG_TOP_LEFT:    top_left    <= pwdata;
        gsm_pkg::REG_TOP_RIGHT:   top_right   <= pwdata;
        gsm_pkg::REG_BOTTOM_LEFT: bottom_left <= pwdata;
        gsm_pkg::REG_ALIGNMENT:   alignment   <= pwdata;
        gsm_pkg::REG_MODULES:     modules     <= pwdata[gsm_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[4:2])
      gsm_pkg::REG_TOP_LEFT:    prdata = top_left;
      gsm_pkg::REG_TOP_RIGHT:   prdata = top_right;
      gsm_pkg::REG_BOTTOM_LEFT: prdata = bottom_left;
      gsm_pkg::REG_ALIGNMENT:   prdata = alignment;
      gsm_pkg::REG_MODULES:     prdata = {24'd0, modules};
      default:                  prdata = '0;
    endcase
  end

  // distances below four act as four
  assign dq = (modules < gsm_pkg::DIST_MIN) ? gsm_pkg::DIST_MIN : modules;

  always_ff @(posedge clk) begin
    dist_clamp <= dq;
    den        <= gsm_pkg::DEN_W'(dq * (dq - gsm_pkg::FINDER_OFS));
  end

  for (genvar a = 0; a < gsm_pkg::AXES; a++) begin : g_axis
    logic [gsm_pkg::COORD_W-1:0] tl_c, tr_c, bl_c, al_c;
    logic [gsm_pkg::COORD_W-1:0] tl_r, tr_r, al_r;

    // axis 0 is x in the high half
    assign tl_c = (a == 0) ? top_left[31:16]    : top_left[15:0];
    assign tr_c = (a == 0) ? top_right[31:16]   : top_right[15:0];
    assign bl_c = (a == 0) ? bottom_left[31:16] : bottom_left[15:0];
    assign al_c = (a == 0) ? alignment[31:16]   : alignment[15:0];

    // products of coordinates and distances
    always_ff @(posedge clk) begin
      tl_r    <= tl_c;
      tr_r    <= tr_c;
      al_r    <= al_c;
      al_d[a] <= gsm_pkg::PROD_W'(al_c * dq);
      bl_m[a] <= gsm_pkg::PROD_W'(bl_c * (dq - gsm_pkg::FINDER_OFS));
      tr_m[a] <= gsm_pkg::PROD_W'(tr_c * (dq - gsm_pkg::FINDER_OFS));
      tl_d[a] <= gsm_pkg::PROD_W'(tl_c * dq);
      tl_3[a] <= 18'(tl_c) + 18'({tl_c, 1'b0});
    end

    // alignment frame steps and top-left frame spans
    always_ff @(posedge clk) begin
      xs[a]     <= $signed({2'b00, al_d[a]}) - $signed({2'b00, bl_m[a]})
                   - $signed({8'd0, tl_3[a]});
      ys[a]     <= $signed({2'b00, al_d[a]}) - $signed({2'b00, tr_m[a]})
                   - $signed({8'd0, tl_3[a]});
      dtr[a]    <= $signed({10'd0, tr_r}) - $signed({10'd0, tl_r});
      dbl[a]    <= $signed({10'd0, bl_c}) - $signed({10'd0, tl_c});
      al_den[a] <= al_r * den;
    end

    assign cfg.ax[a].tl_d   = tl_d[a];
    assign cfg.ax[a].al_den = al_den[a];
    assign cfg.ax[a].xs     = xs[a];
    assign cfg.ax[a].ys     = ys[a];
    assign cfg.ax[a].dtr    = dtr[a];
    assign cfg.ax[a].dbl    = dbl[a];
  end

  assign cfg.dist_now   = dq;
  assign cfg.dist_clamp = dist_clamp;
  assign cfg.den        = den;

endmodule
`default_nettype wire

// ----- rtl/gsm_front.sv -----
// Frame choice, products and numerator stages ahead of the dividers.
`default_nettype none
module gsm_front (
  input  wire logic                               clk,
  input  wire logic [gsm_pkg::FRONT_STAGES-1:0]   en,
  input  wire logic [gsm_pkg::IDX_W-1:0]          module_column,
  input  wire logic [gsm_pkg::IDX_W-1:0]          module_row,
  input  gsm_pkg::cfg_t                           cfg,
  output gsm_pkg::div_in_t [gsm_pkg::AXES-1:0]    div_in,
  output logic                                    frame
);

  logic [gsm_pkg::IDX_W-1:0] col0, row0, col1, row1;
  logic frame1, frame2, frame3, frame4, frame5;
  logic signed [gsm_pkg::OFS_W-1:0] c1, c2;
  logic [gsm_pkg::DIST_W-1:0] ofs;

  // stage 0: capture indices
  always_ff @(posedge clk) begin
    if (en[0]) begin
      col0 <= module_column;
      row0 <= module_row;
    end
  end

  // stage 1: frame choice
  always_ff @(posedge clk) begin
    if (en[1]) begin
      col1   <= col0;
      row1   <= row0;
      frame1 <= !(col0 < cfg.dist_now && row0 < cfg.dist_now);
    end
  end

  // stage 2: index offsets
  assign ofs = frame1 ? cfg.dist_clamp : gsm_pkg::FINDER_OFS;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      frame2 <= frame1;
      c1     <= $signed({2'b00, col1}) - $signed({2'b00, ofs});
      c2     <= $signed({2'b00, row1}) - $signed({2'b00, ofs});
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) frame3 <= frame2;
    if (en[4]) frame4 <= frame3;
    if (en[5]) frame5 <= frame4;
  end

  for (genvar a = 0; a < gsm_pkg::AXES; a++) begin : g_axis
    logic signed [gsm_pkg::NUM_W-1:0] p0, p1, p2, num;
    logic signed [gsm_pkg::STEP_W-1:0] s1, s2;
    logic [gsm_pkg::NUM_W-1:0] mag;
    logic [gsm_pkg::DEN_W-1:0] den;
    logic [gsm_pkg::RN_W-1:0]  rn;
    logic [gsm_pkg::D2_W-1:0]  d2;

    assign s1 = frame2 ? cfg.ax[a].xs : cfg.ax[a].dtr;
    assign s2 = frame2 ? cfg.ax[a].ys : cfg.ax[a].dbl;

    // stage 3: the three products
    always_ff @(posedge clk) begin
      if (en[3]) begin
        p0 <= frame2 ? $signed({4'd0, cfg.ax[a].al_den})
                     : $signed({12'd0, cfg.ax[a].tl_d});
        p1 <= s1 * c1;
        p2 <= s2 * c2;
      end
    end

    // stage 4: numerator
    always_ff @(posedge clk) begin
      if (en[4]) num <= p0 + p1 + p2;
    end

    // stage 5: magnitude, rounding bias and range check
    assign mag = num[gsm_pkg::NUM_W-1] ? gsm_pkg::NUM_W'(-num) : gsm_pkg::NUM_W'(num);
    assign den = frame4 ? cfg.den : gsm_pkg::DEN_W'(cfg.dist_clamp);
    assign rn  = {mag, 1'b0} + gsm_pkg::RN_W'(den);
    assign d2  = {den, 1'b0};

    always_ff @(posedge clk) begin
      if (en[5]) begin
        div_in[a].rn  <= rn;
        div_in[a].d2  <= d2;
        div_in[a].neg <= num[gsm_pkg::NUM_W-1];
        div_in[a].ovf <= rn >= {2'b00, d2, {gsm_pkg::Q_W{1'b0}}};
      end
    end
  end

  assign frame = frame5;

endmodule
`default_nettype wire

// ----- rtl/gsm_div.sv -----
// Pipelined restoring divider with rounding saturation for one axis.
`default_nettype none
module gsm_div (
  input  wire logic                              clk,
  input  wire logic [gsm_pkg::DIV_STAGES:0]      en,
  input  gsm_pkg::div_in_t                       din,
  output logic signed [gsm_pkg::OUT_W-1:0]       sample
);

  logic [gsm_pkg::RN_W-1:0] r   [gsm_pkg::DIV_STAGES-1];
  logic [gsm_pkg::Q_W-1:0]  q   [gsm_pkg::DIV_STAGES];
  logic [gsm_pkg::D2_W-1:0] d2  [gsm_pkg::DIV_STAGES-1];
  logic                     neg [gsm_pkg::DIV_STAGES];
  logic                     ovf [gsm_pkg::DIV_STAGES];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < gsm_pkg::DIV_STAGES; k++) begin : g_stage
    localparam int B = gsm_pkg::Q_W - 1 - k;
    logic [gsm_pkg::RN_W-1:0] src_r, sh;
    logic [gsm_pkg::Q_W-1:0]  src_q;
    logic [gsm_pkg::D2_W-1:0] src_d2;
    logic                     src_neg, src_ovf, geq;

    if (k == 0) begin : g_first
      assign src_r   = din.rn;
      assign src_q   = '0;
      assign src_d2  = din.d2;
      assign src_neg = din.neg;
      assign src_ovf = din.ovf;
    end else begin : g_next
      assign src_r   = r[k-1];
      assign src_q   = q[k-1];
      assign src_d2  = d2[k-1];
      assign src_neg = neg[k-1];
      assign src_ovf = ovf[k-1];
    end

    assign sh  = gsm_pkg::RN_W'(src_d2) << B;
    assign geq = src_r >= sh;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        q[k]   <= src_q | (gsm_pkg::Q_W'(geq) << B);
        neg[k] <= src_neg;
        ovf[k] <= src_ovf;
      end
    end

    // the last stage keeps only the quotient
    if (k < gsm_pkg::DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[k]) begin
          r[k]  <= geq ? src_r - sh : src_r;
          d2[k] <= src_d2;
        end
      end
    end
  end

  // saturate and apply sign
  logic [gsm_pkg::Q_W-1:0] qf;
  logic                    big;
  logic signed [gsm_pkg::OUT_W-1:0] res;

  assign qf = q[gsm_pkg::DIV_STAGES-1];

  always_comb begin
    if (neg[gsm_pkg::DIV_STAGES-1]) begin
      big = ovf[gsm_pkg::DIV_STAGES-1] || (qf > gsm_pkg::NEG_LIMIT);
      res = big ? gsm_pkg::OUT_MIN : -$signed(qf);
    end else begin
      big = ovf[gsm_pkg::DIV_STAGES-1] || qf[gsm_pkg::Q_W-1];
      res = big ? gsm_pkg::OUT_MAX : $signed(qf);
    end
  end

  always_ff @(posedge clk) begin
    if (en[gsm_pkg::DIV_STAGES]) sample <= res;
  end

endmodule
`default_nettype wire

// ----- rtl/grid_module_sample_point_mapper.sv -----
// Top level of the grid module sample point mapper.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_stall | module_column, module_row
//  output   | out_valid/out_stall | sample_x, sample_y, used_alignment_frame
//  config   | APB, pready tied 1  | paddr, pwdata, prdata
//
// One item per clock while the output is not stalled: six front stages (capture,
// frame choice, index offsets, products, numerator, rounding bias) and eighteen
// divider stages, one quotient bit each, then the output register.
// Reset is synchronous and empties the pipeline; registers go to defaults.
// A stall holds the output; earlier stages keep moving into empty slots, so
// in_stall rises only when every stage holds an item.
`default_nettype none
module grid_module_sample_point_mapper (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [gsm_pkg::IDX_W-1:0]         module_column,
  input  wire logic [gsm_pkg::IDX_W-1:0]         module_row,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [gsm_pkg::OUT_W-1:0]       sample_x,
  output logic signed [gsm_pkg::OUT_W-1:0]       sample_y,
  output logic                                   used_alignment_frame,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [gsm_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [gsm_pkg::DATA_W-1:0]        pwdata,
  output logic      [gsm_pkg::DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int F = gsm_pkg::FRONT_STAGES;
  localparam int N = gsm_pkg::PIPE_DEPTH;

  gsm_pkg::cfg_t                          cfg;
  gsm_pkg::div_in_t [gsm_pkg::AXES-1:0]   div_in;
  logic [N-1:0] v;
  logic [N-1:0] en;
  logic         frame5;
  logic [gsm_pkg::DIV_STAGES:0] frame_pipe;

  assign pready = 1'b1;

  gsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // a stage moves when it is empty or the next one moves
  assign en[N-1] = !v[N-1] || !out_stall;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign in_stall = !en[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  gsm_front u_front (
    .clk           (clk),
    .en            (en[F-1:0]),
    .module_column (module_column),
    .module_row    (module_row),
    .cfg           (cfg),
    .div_in        (div_in),
    .frame         (frame5)
  );

  gsm_div u_div_x (
    .clk    (clk),
    .en     (en[N-1:F]),
    .din    (div_in[0]),
    .sample (sample_x)
  );

  gsm_div u_div_y (
    .clk    (clk),
    .en     (en[N-1:F]),
    .din    (div_in[1]),
    .sample (sample_y)
  );

  // frame flag alongside the divider stages
  always_ff @(posedge clk) begin
    if (en[F]) frame_pipe[0] <= frame5;
    for (int k = 1; k <= gsm_pkg::DIV_STAGES; k++) begin
      if (en[F+k]) frame_pipe[k] <= frame_pipe[k-1];
    end
  end

  assign out_valid            = v[N-1];
  assign used_alignment_frame = frame_pipe[gsm_pkg::DIV_STAGES];

  // input backs up only with every stage occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&v))
    else $error("input stalled with an empty stage");

  // occupancy grows by one on a lone accept
  a_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !(out_valid && !out_stall)) |=>
      ($countones(v) == $past($countones(v)) + 1))
    else $error("item lost or duplicated in pipeline");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the grid module sample point mapper: directed and random mappings.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int LATENCY = gsm_pkg::PIPE_DEPTH;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [gsm_pkg::IDX_W-1:0] module_column = '0;
  logic [gsm_pkg::IDX_W-1:0] module_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [gsm_pkg::OUT_W-1:0] sample_x, sample_y;
  logic used_alignment_frame;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [gsm_pkg::ADDR_W-1:0] paddr = '0;
  logic [gsm_pkg::DATA_W-1:0] pwdata = '0;
  logic [gsm_pkg::DATA_W-1:0] prdata;
  logic pready;

  typedef struct packed {
    logic signed [gsm_pkg::OUT_W-1:0] x;
    logic signed [gsm_pkg::OUT_W-1:0] y;
    logic                             frame;
  } point_t;

  // local copy of the configuration
  logic [31:0] tl_pt, tr_pt, bl_pt, al_pt;
  logic [7:0]  dist_reg;

  point_t expected_points[$];
  int errors = 0;
  int mapped = 0;
  int align_hits = 0;
  longint cycles = 0;
  bit quiet_in = 1'b0;   // stretch with no input gaps
  bit quiet_out = 1'b0;  // stretch with no output stalls

  grid_module_sample_point_mapper uut (.*);

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_module_sample_point_mapper test failed");
      $finish;
    end
  end

  // round num/den to nearest, ties away from zero, saturate
  function automatic logic signed [gsm_pkg::OUT_W-1:0] round_clip(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return q[gsm_pkg::OUT_W-1:0];
  endfunction

  function automatic logic signed [gsm_pkg::OUT_W-1:0] axis_point(bit alt, longint tl,
      longint tr, longint bl, longint al, longint d, longint c, longint r);
    longint den, xs, ys;
    if (!alt) return round_clip(tl * d + (tr - tl) * (c - 3) + (bl - tl) * (r - 3), d);
    den = d * (d - 3);
    xs = al * d - bl * (d - 3) - 3 * tl;
    ys = al * d - tr * (d - 3) - 3 * tl;
    return round_clip(al * den + xs * (c - d) + ys * (r - d), den);
  endfunction

  function automatic point_t map_module(logic [7:0] c, logic [7:0] r);
    point_t p;
    longint d;
    d = (dist_reg < 4) ? 4 : dist_reg;
    p.frame = !(c < d && r < d);
    p.x = axis_point(p.frame, tl_pt[31:16], tr_pt[31:16], bl_pt[31:16], al_pt[31:16],
                     d, c, r);
    p.y = axis_point(p.frame, tl_pt[15:0], tr_pt[15:0], bl_pt[15:0], al_pt[15:0],
                     d, c, r);
    return p;
  endfunction

  // APB register write, setup then access
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      gsm_pkg::REG_TOP_LEFT:    tl_pt = value;
      gsm_pkg::REG_TOP_RIGHT:   tr_pt = value;
      gsm_pkg::REG_BOTTOM_LEFT: bl_pt = value;
      gsm_pkg::REG_ALIGNMENT:   al_pt = value;
      gsm_pkg::REG_MODULES:     dist_reg = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(logic [31:0] tl, logic [31:0] tr, logic [31:0] bl,
                           logic [31:0] al, logic [7:0] d);
    write_reg(gsm_pkg::REG_TOP_LEFT, tl);
    write_reg(gsm_pkg::REG_TOP_RIGHT, tr);
    write_reg(gsm_pkg::REG_BOTTOM_LEFT, bl);
    write_reg(gsm_pkg::REG_ALIGNMENT, al);
    write_reg(gsm_pkg::REG_MODULES, d);
  endtask

  // send one item; predict on acceptance; valid stays up for the next item
  task automatic send_module(logic [7:0] c, logic [7:0] r);
    @(negedge clk);
    while (!quiet_in && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    module_column <= c;
    module_row <= r;
    do @(posedge clk); while (in_stall);
    expected_points.insert(expected_points.size(), map_module(c, r));
    mapped++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // output stall pattern
  always @(negedge clk)
    if (!rst) out_stall <= !quiet_out && ($urandom_range(99) < 26);

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      point_t e;
      if (expected_points.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", sample_x, sample_y);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (used_alignment_frame) align_hits++;
        if (sample_x !== e.x) begin
          $error("sample_x expected %0d got %0d", e.x, sample_x); errors++;
        end
        if (sample_y !== e.y) begin
          $error("sample_y expected %0d got %0d", e.y, sample_y); errors++;
        end
        if (used_alignment_frame !== e.frame) begin
          $error("used_alignment_frame expected %0b got %0b", e.frame,
                 used_alignment_frame); errors++;
        end
      end
    end
  end

  // reset values, grid corners and beyond
  task automatic test_reset_defaults();
    send_module(0, 0);
    send_module(13, 13);
    send_module(14, 0);
    send_module(255, 255);
    wait_drain();
  endtask

  // typical grid with directed corner cases, extremes of every field
  task automatic test_directed();
    set_frame({16'd800, 16'd800}, {16'd4000, 16'd820}, {16'd780, 16'd4000},
              {16'd3700, 16'd3700}, 8'd18);
    send_module(0, 0);
    send_module(17, 17);
    send_module(18, 0);
    send_module(0, 18);
    send_module(24, 24);
    send_module(176, 176);
    send_module(255, 0);
    send_module(0, 255);
    send_module(8'hAA, 8'h55);
    send_module(8'h55, 8'hAA);
    wait_drain();
    // small distance is clamped to four
    set_frame(32'hFFFF_FFFF, 32'h0, 32'hFFFF_0000, 32'h0000_FFFF, 8'd0);
    send_module(3, 3);
    send_module(4, 2);
    send_module(255, 255);
    send_module(0, 0);
    wait_drain();
    write_reg(gsm_pkg::REG_MODULES, 8'd3);
    send_module(3, 3);
    send_module(3, 4);
    wait_drain();
    // largest distance, saturation on the way
    set_frame(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'd255);
    send_module(254, 254);
    send_module(255, 0);
    send_module(0, 0);
    wait_drain();
  endtask

  // random configurations with random modules
  task automatic test_random(int phases, int per_phase);
    logic [7:0] d;
    for (int p = 0; p < phases; p++) begin
      d = (p % 4 == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(170, 14));
      if ($urandom_range(3) == 0)
        set_frame($urandom, $urandom, $urandom, $urandom, d);
      else
        set_frame({16'($urandom_range(2000, 100)), 16'($urandom_range(2000, 100))},
                  {16'($urandom_range(30000, 8000)), 16'($urandom_range(3000, 100))},
                  {16'($urandom_range(3000, 100)), 16'($urandom_range(30000, 8000))},
                  {16'($urandom_range(30000, 7000)), 16'($urandom_range(30000, 7000))},
                  d);
      quiet_in = (p == 2);
      quiet_out = (p == 2);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(9) == 0)
          send_module(8'($urandom), 8'($urandom));
        else
          send_module(8'($urandom_range(d + 7)), 8'($urandom_range(d + 7)));
      end
      wait_drain();
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    tl_pt = 0; tr_pt = 0; bl_pt = 0; al_pt = 0; dist_reg = gsm_pkg::DIST_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed();
    test_random(10, 40);
    $display("Mapped %0d modules over 15 register settings, %0d in the alignment frame.",
             mapped, align_hits);
    if (errors == 0 && expected_points.size() == 0)
      $display("grid_module_sample_point_mapper test passed");
    else
      $display("grid_module_sample_point_mapper test failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/gsm_pkg.sv
rtl/gsm_cfg.sv
rtl/gsm_front.sv
rtl/gsm_div.sv
rtl/grid_module_sample_point_mapper.sv
tb/tb.sv
